// ----- rtl/sha1bs_pkg.sv -----
// Shared types and constants for the SHA-1 byte stream hash.
// Beat payload structs, controller/datapath command and status, round constants.
// No dependencies.
package sha1bs_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        final_word;
  } out_item_t;

  typedef enum logic [1:0] {
    BSEL_IN,
    BSEL_PAD,
    BSEL_ZERO,
    BSEL_LEN
  } bsel_t;

  typedef struct packed {
    logic  shift_byte;
    bsel_t bsel;
    logic  count_inc;
    logic  cmp_start;
    logic  cmp_round;
    logic  cmp_fold;
    logic  out_load;
    logic  msg_clear;
  } dp_cmd_t;

  typedef struct packed {
    logic pos_last;
    logic pos_tail;
    logic rnd_last;
    logic out_free;
    logic word_last;
  } dp_sts_t;

  localparam int unsigned NUM_WORDS = 5;

  localparam logic [31:0] IV [NUM_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] RC [4] = '{
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [6:0] RND_LAST  = 7'd79;
  localparam logic [2:0] WORD_LAST = 3'd4;
  localparam logic [5:0] POS_LAST  = 6'd63;

  function automatic logic [31:0] round_f(input logic [1:0] ph, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] res;
    unique case (ph)
      2'd0:    res = (b & c) | (~b & d);
      2'd2:    res = (b & c) | (b & d) | (c & d);
      default: res = b ^ c ^ d;
    endcase
    return res;
  endfunction

endpackage

// ----- rtl/sha1_byte_stream_hash.sv -----
// SHA-1 over a byte stream. The 64th byte of each block starts a compression:
// 80 rounds, one per cycle, then a chain fold.
// End item: per final block, padding up to byte 63, then compression, then
// 5 result beats. Two final blocks when the pad byte lands at byte 56 or later.
// Input stalls in every state but idle; all rounds run on the single shared round unit.
// Reset (rst_n, synchronous, active low): chain to the initial vector, counters
// cleared, no clearing pass; block and output payload registers are not reset.
module sha1_byte_stream_hash (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sha1bs_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sha1bs_pkg::out_item_t out_data
);

  sha1bs_pkg::dp_cmd_t cmd;
  sha1bs_pkg::dp_sts_t sts;

  sha1bs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .sts      (sts),
    .cmd      (cmd)
  );

  sha1bs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/sha1bs_dp.sv -----
// SHA-1 datapath: 512-bit block/schedule shift line, working and chain registers,
// counters and the digest output register. Driven by sha1bs_ctrl.
// Depends on sha1bs_pkg.
module sha1bs_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sha1bs_pkg::in_item_t  in_data,
  input  sha1bs_pkg::dp_cmd_t   cmd,
  output sha1bs_pkg::dp_sts_t   sts,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sha1bs_pkg::out_item_t out_data
);

  logic [511:0]          blk_r;
  logic [31:0]           chain_r [sha1bs_pkg::NUM_WORDS];
  logic [31:0]           wr_r    [sha1bs_pkg::NUM_WORDS];
  logic [5:0]            pos_r;
  logic [60:0]           cnt_r;
  logic [6:0]            rnd_r;
  logic [2:0]            idx_r;
  logic                  out_valid_r;
  sha1bs_pkg::out_item_t out_item_r;

  logic [7:0]  byte_sel;
  logic [63:0] len_bits;
  logic [5:0]  len_off;
  logic [31:0] w_now;
  logic [31:0] w_mix;
  logic [31:0] w_new;
  logic [1:0]  ph;
  logic [31:0] f_val;
  logic [31:0] t_val;

  assign len_bits = {cnt_r, 3'b000};
  assign len_off  = {3'd7 - pos_r[2:0], 3'b000};

  always_comb begin
    unique case (cmd.bsel)
      sha1bs_pkg::BSEL_IN:   byte_sel = in_data.data_byte;
      sha1bs_pkg::BSEL_PAD:  byte_sel = sha1bs_pkg::PAD_BYTE;
      sha1bs_pkg::BSEL_ZERO: byte_sel = 8'h00;
      sha1bs_pkg::BSEL_LEN:  byte_sel = len_bits[len_off +: 8];
      default:               byte_sel = 8'h00;
    endcase
  end

  // oldest word at the top; taps for W[t], W[t+2], W[t+8], W[t+13]
  assign w_now = blk_r[511:480];
  assign w_mix = blk_r[511:480] ^ blk_r[447:416] ^ blk_r[255:224] ^ blk_r[95:64];
  assign w_new = {w_mix[30:0], w_mix[31]};

  always_comb begin
    priority if (rnd_r < 7'd20) ph = 2'd0;
    else if (rnd_r < 7'd40)     ph = 2'd1;
    else if (rnd_r < 7'd60)     ph = 2'd2;
    else                        ph = 2'd3;
  end

  assign f_val = sha1bs_pkg::round_f(ph, wr_r[1], wr_r[2], wr_r[3]);
  assign t_val = {wr_r[0][26:0], wr_r[0][31:27]} + f_val + wr_r[4]
               + sha1bs_pkg::RC[ph] + w_now;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      cnt_r       <= '0;
      rnd_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < sha1bs_pkg::NUM_WORDS; i++) begin
        chain_r[i] <= sha1bs_pkg::IV[i];
        wr_r[i]    <= '0;
      end
    end else begin
      if (cmd.shift_byte) pos_r <= pos_r + 6'd1;
      if (cmd.count_inc)  cnt_r <= cnt_r + 61'd1;
      if (cmd.cmp_start) begin
        rnd_r <= '0;
        for (int i = 0; i < sha1bs_pkg::NUM_WORDS; i++) wr_r[i] <= chain_r[i];
      end else if (cmd.cmp_round) begin
        rnd_r   <= (rnd_r == sha1bs_pkg::RND_LAST) ? 7'd0 : rnd_r + 7'd1;
        wr_r[0] <= t_val;
        wr_r[1] <= wr_r[0];
        wr_r[2] <= {wr_r[1][1:0], wr_r[1][31:2]};
        wr_r[3] <= wr_r[2];
        wr_r[4] <= wr_r[3];
      end
      if (cmd.cmp_fold) begin
        for (int i = 0; i < sha1bs_pkg::NUM_WORDS; i++) chain_r[i] <= chain_r[i] + wr_r[i];
      end
      if (cmd.out_load) begin
        idx_r <= (idx_r == sha1bs_pkg::WORD_LAST) ? 3'd0 : idx_r + 3'd1;
      end
      if (cmd.out_load)      out_valid_r <= 1'b1;
      else if (!out_stall)   out_valid_r <= 1'b0;
      if (cmd.msg_clear) begin
        pos_r <= '0;
        cnt_r <= '0;
        for (int i = 0; i < sha1bs_pkg::NUM_WORDS; i++) chain_r[i] <= sha1bs_pkg::IV[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift_byte)     blk_r <= {blk_r[503:0], byte_sel};
    else if (cmd.cmp_round) blk_r <= {blk_r[479:0], w_new};
    if (cmd.out_load) begin
      out_item_r.digest_word <= chain_r[idx_r];
      out_item_r.word_number <= idx_r;
      out_item_r.final_word  <= (idx_r == sha1bs_pkg::WORD_LAST);
    end
  end

  assign sts.pos_last  = (pos_r == sha1bs_pkg::POS_LAST);
  assign sts.pos_tail  = (pos_r[5:3] == 3'b111);
  assign sts.rnd_last  = (rnd_r == sha1bs_pkg::RND_LAST);
  assign sts.out_free  = !out_valid_r || !out_stall;
  assign sts.word_last = (idx_r == sha1bs_pkg::WORD_LAST);

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  a_start_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cmp_start |=> pos_r == 6'd0)
    else $error("compression started off a block boundary");

  a_fold_after_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cmp_fold |-> rnd_r == 7'd0 && $past(cmd.cmp_round))
    else $error("fold without completing 80 rounds");

  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.msg_clear |-> cmd.out_load && idx_r == sha1bs_pkg::WORD_LAST)
    else $error("message cleared before last digest word");

  a_no_load_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && out_stall))
    else $error("digest word overwritten while held");

endmodule

// ----- rtl/sha1bs_ctrl.sv -----
// SHA-1 controller: sequences byte intake, padding, 80-round compression
// and digest readout by commands to sha1bs_dp. Depends on sha1bs_pkg.
module sha1bs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sha1bs_pkg::in_item_t in_data,
  input  sha1bs_pkg::dp_sts_t  sts,
  output sha1bs_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROUND,
    S_FOLD,
    S_PAD,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   eom_pend_r, eom_pend_nxt;
  logic   need_wrap_r, need_wrap_nxt;
  logic   pad_first_r, pad_first_nxt;
  logic   final_r, final_nxt;
  logic   in_accept;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    logic wrap_now;
    wrap_now      = 1'b0;
    state_nxt     = state_r;
    eom_pend_nxt  = eom_pend_r;
    need_wrap_nxt = need_wrap_r;
    pad_first_nxt = pad_first_r;
    final_nxt     = final_r;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          eom_pend_nxt  = in_data.end_of_message;
          pad_first_nxt = 1'b1;
          if (in_data.byte_present) begin
            cmd.shift_byte = 1'b1;
            cmd.bsel       = sha1bs_pkg::BSEL_IN;
            cmd.count_inc  = 1'b1;
          end
          if (in_data.byte_present && sts.pos_last) begin
            cmd.cmp_start = 1'b1;
            final_nxt     = 1'b0;
            state_nxt     = S_ROUND;
          end else if (in_data.end_of_message) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_ROUND: begin
        cmd.cmp_round = 1'b1;
        if (sts.rnd_last) state_nxt = S_FOLD;
      end
      S_FOLD: begin
        cmd.cmp_fold = 1'b1;
        priority if (final_r) state_nxt = S_OUT;
        else if (eom_pend_r)  state_nxt = S_PAD;
        else                  state_nxt = S_IDLE;
      end
      S_PAD: begin
        cmd.shift_byte = 1'b1;
        priority if (pad_first_r)                cmd.bsel = sha1bs_pkg::BSEL_PAD;
        else if (sts.pos_tail && !need_wrap_r)   cmd.bsel = sha1bs_pkg::BSEL_LEN;
        else                                     cmd.bsel = sha1bs_pkg::BSEL_ZERO;
        // pad byte landing in the length field pushes the length to an extra block
        wrap_now      = need_wrap_r || (pad_first_r && sts.pos_tail);
        pad_first_nxt = 1'b0;
        need_wrap_nxt = wrap_now;
        if (sts.pos_last) begin
          cmd.cmp_start = 1'b1;
          final_nxt     = !wrap_now;
          need_wrap_nxt = 1'b0;
          state_nxt     = S_ROUND;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.word_last) begin
            cmd.msg_clear = 1'b1;
            eom_pend_nxt  = 1'b0;
            final_nxt     = 1'b0;
            state_nxt     = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      eom_pend_r  <= 1'b0;
      need_wrap_r <= 1'b0;
      pad_first_r <= 1'b0;
      final_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      eom_pend_r  <= eom_pend_nxt;
      need_wrap_r <= need_wrap_nxt;
      pad_first_r <= pad_first_nxt;
      final_r     <= final_nxt;
    end
  end

  a_final_has_eom: assert property (@(posedge clk) disable iff (!rst_n)
    final_r |-> eom_pend_r)
    else $error("final block flagged outside padding");

  a_len_after_pad: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift_byte && cmd.bsel == sha1bs_pkg::BSEL_LEN |-> !pad_first_r && eom_pend_r)
    else $error("length byte before pad byte");

  a_out_from_fold: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == S_OUT) |-> $past(state_r == S_FOLD) && $past(final_r))
    else $error("digest readout not after final block");

endmodule
